@@ design/pds_pkg.sv @@
// ----------------------------------------------------------------------------
// pds_pkg
// shared types and constants for the prime divisor sum unit
// ----------------------------------------------------------------------------
package pds_pkg;

  // first odd trial divisor and the step between trial divisors
  localparam int FIRST_ODD = 3;
  localparam int ODD_STEP  = 2;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;       // capture magnitude of the input value, clear the sum
    logic add_two;    // add the factor 2 to the sum
    logic shift_rem;  // strip one factor 2 from the remaining value
    logic set_d3;     // set the trial divisor to the first odd value
    logic div_start;  // start a division of the remaining value by the divisor
    logic div_step;   // one restoring step of the division
    logic take_q;     // remaining value takes the quotient
    logic add_d;      // add the divisor to the sum
    logic next_d;     // move to the next odd divisor
    logic add_rem;    // add the remaining value as the last prime
    logic out_write;  // load the output register with the sum
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic rem_lt2;   // remaining value below 2
    logic rem_odd;   // remaining value is odd
    logic rem_gt1;   // remaining value above 1
    logic div_last;  // this division step is the last one
    logic d_gt_q;    // divisor exceeds the quotient
    logic r_zero;    // division remainder is zero
  } sts_t;

endpackage

@@ design/pds_if.sv @@
// ----------------------------------------------------------------------------
// pds_in_if / pds_out_if
// valid/ready channels for input values and factor sums
// ----------------------------------------------------------------------------
interface pds_in_if #(
  parameter int VALUE_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface pds_out_if #(
  parameter int VALUE_BITS = 32
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] factor_sum;

  modport source (output valid, output factor_sum, input ready);
  modport sink   (input valid, input factor_sum, output ready);
endinterface

@@ design/prime_divisor_sum_unit.sv @@
// ----------------------------------------------------------------------------
// prime_divisor_sum_unit: sum of distinct prime factors by trial division
// one item at a time; each division runs in the shared restoring divider,
// one restoring step per quotient bit
// async reset clears control
// ----------------------------------------------------------------------------
module prime_divisor_sum_unit #(
  parameter int VALUE_BITS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pds_in_if.sink    in_i,
  pds_out_if.source out_o
);

  pds_pkg::cmd_t cmd;
  pds_pkg::sts_t sts;

  // sequencer: load, strip twos, then one division per odd trial or per
  // repeated factor; the result sits in the output register until its transfer
  // while the next item may already be taken in
  pds_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // datapath: a single division gives both the remainder test and the
  // quotient used for the divisor squared bound
  pds_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .value_i      (in_i.value),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .factor_sum_o (out_o.factor_sum)
  );

endmodule

@@ design/pds_datapath.sv @@
// ----------------------------------------------------------------------------
// pds_datapath
// remaining value, trial divisor, sum, restoring divider and output register
// ----------------------------------------------------------------------------
module pds_datapath #(
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic signed [VALUE_BITS-1:0] value_i,
  input  pds_pkg::cmd_t                cmd_i,
  output pds_pkg::sts_t                sts_o,
  output logic        [VALUE_BITS-1:0] factor_sum_o
);

  localparam int CntW = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

  logic [VALUE_BITS-1:0] rem_q, rem_d;
  logic [VALUE_BITS-1:0] div_q, div_d;
  logic [VALUE_BITS-1:0] sum_q, sum_d;
  logic [VALUE_BITS-1:0] acc_q, acc_d;   // partial remainder
  logic [VALUE_BITS-1:0] dq_q, dq_d;     // dividend shifting out, quotient shifting in
  logic [VALUE_BITS-1:0] out_q, out_d;
  logic [CntW-1:0]       cnt_q, cnt_d;

  logic [VALUE_BITS-1:0] mag;
  logic [VALUE_BITS:0]   trial;
  logic                  trial_neg;

  assign mag = value_i[VALUE_BITS-1] ? (~value_i + 1'b1) : value_i;

  assign trial     = {acc_q, dq_q[VALUE_BITS-1]} - {1'b0, div_q};
  assign trial_neg = trial[VALUE_BITS];

  always_comb begin
    rem_d = rem_q;
    div_d = div_q;
    sum_d = sum_q;
    acc_d = acc_q;
    dq_d  = dq_q;
    out_d = out_q;
    cnt_d = cnt_q;

    if (cmd_i.load) begin
      rem_d = mag;
      sum_d = '0;
    end
    if (cmd_i.add_two) begin
      sum_d = sum_q + VALUE_BITS'(pds_pkg::ODD_STEP);
    end
    if (cmd_i.shift_rem) begin
      rem_d = rem_q >> 1;
    end
    if (cmd_i.set_d3) begin
      div_d = VALUE_BITS'(pds_pkg::FIRST_ODD);
    end
    if (cmd_i.next_d) begin
      div_d = div_q + VALUE_BITS'(pds_pkg::ODD_STEP);
    end
    if (cmd_i.add_d) begin
      sum_d = sum_q + div_q;
    end
    if (cmd_i.add_rem) begin
      sum_d = sum_q + rem_q;
    end
    if (cmd_i.take_q) begin
      rem_d = dq_q;
    end
    if (cmd_i.div_start) begin
      acc_d = '0;
      dq_d  = cmd_i.take_q ? dq_q : rem_q;
      cnt_d = '0;
    end
    if (cmd_i.div_step) begin
      if (trial_neg) begin
        acc_d = {acc_q[VALUE_BITS-2:0], dq_q[VALUE_BITS-1]};
      end else begin
        acc_d = trial[VALUE_BITS-1:0];
      end
      dq_d  = {dq_q[VALUE_BITS-2:0], ~trial_neg};
      cnt_d = cnt_q + 1'b1;
    end
    if (cmd_i.out_write) begin
      out_d = sum_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      div_q <= '0;
      sum_q <= '0;
      cnt_q <= '0;
    end else begin
      rem_q <= rem_d;
      div_q <= div_d;
      sum_q <= sum_d;
      cnt_q <= cnt_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    dq_q  <= dq_d;
    out_q <= out_d;
  end

  assign sts_o.rem_lt2  = (rem_q < VALUE_BITS'(2));
  assign sts_o.rem_odd  = rem_q[0];
  assign sts_o.rem_gt1  = (rem_q > VALUE_BITS'(1));
  assign sts_o.div_last = (cnt_q == CntW'(VALUE_BITS - 1));
  assign sts_o.d_gt_q   = (div_q > dq_q);
  assign sts_o.r_zero   = (acc_q == '0);

  assign factor_sum_o = out_q;

endmodule

@@ design/pds_controller.sv @@
// ----------------------------------------------------------------------------
// pds_controller
// sequencer for factor stripping, trial division and result transfer
// ----------------------------------------------------------------------------
module pds_controller (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output pds_pkg::cmd_t cmd_o,
  input  pds_pkg::sts_t sts_i
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StCheck = 3'd1;
  localparam logic [2:0] StStrip = 3'd2;
  localparam logic [2:0] StDiv   = 3'd3;
  localparam logic [2:0] StEval  = 3'd4;
  localparam logic [2:0] StFin   = 3'd5;

  logic [2:0] state_q, state_d;
  logic       found_q, found_d;     // dividing out the current divisor
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    found_d     = found_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StCheck;
        end
      end
      StCheck: begin
        if (sts_i.rem_lt2) begin
          state_d = StFin;
        end else if (!sts_i.rem_odd) begin
          cmd_o.add_two = 1'b1;
          state_d       = StStrip;
        end else begin
          cmd_o.set_d3    = 1'b1;
          cmd_o.div_start = 1'b1;
          found_d         = 1'b0;
          state_d         = StDiv;
        end
      end
      StStrip: begin
        if (sts_i.rem_odd) begin
          cmd_o.set_d3    = 1'b1;
          cmd_o.div_start = 1'b1;
          found_d         = 1'b0;
          state_d         = StDiv;
        end else begin
          cmd_o.shift_rem = 1'b1;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = StEval;
        end
      end
      StEval: begin
        if (found_q) begin
          // keep dividing out the factor just found
          if (sts_i.r_zero) begin
            cmd_o.take_q = 1'b1;
          end else begin
            cmd_o.next_d = 1'b1;
            found_d      = 1'b0;
          end
          cmd_o.div_start = 1'b1;
          state_d         = StDiv;
        end else if (sts_i.d_gt_q) begin
          // divisor squared beyond the remaining value
          cmd_o.add_rem = sts_i.rem_gt1;
          state_d       = StFin;
        end else if (sts_i.r_zero) begin
          cmd_o.add_d     = 1'b1;
          cmd_o.take_q    = 1'b1;
          cmd_o.div_start = 1'b1;
          found_d         = 1'b1;
          state_d         = StDiv;
        end else begin
          cmd_o.next_d    = 1'b1;
          cmd_o.div_start = 1'b1;
          state_d         = StDiv;
        end
      end
      StFin: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_write = 1'b1;
          out_valid_d     = 1'b1;
          state_d         = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
